[hw/rtl/nmea_rmc_pkg.sv]
// Shared constants and types for the NMEA RMC time parser.
package nmea_rmc_pkg;

    // Time field character count saturates here
    localparam int TIME_FIELD_MAX = 16;
    localparam int FIELD_CNT_W    = $clog2(TIME_FIELD_MAX + 1);

    // Digit nibble and hour offset widths
    localparam int DIGIT_W = 4;
    localparam int TZ_W    = 4;

    // Reset value of the timezone offset register
    localparam logic [TZ_W-1:0] TZ_RESET = TZ_W'(4);

    typedef logic [DIGIT_W-1:0] digit_t;

    // Hour digit pair handed to and from the hour adjuster
    typedef struct packed {
        digit_t tens;
        digit_t ones;
    } hour_pair_t;

endpackage

[hw/rtl/nmea_rmc_time_parser_core.sv]
// Top level: NMEA $GPRMC time parser with stream input and output.
//
// Takes one received character per beat on the s_ side and emits one beat on
// the m_ side with the local hour and minute digits for every $GPRMC sentence
// whose checksum matches. A character is accepted every cycle while the
// result side keeps up; the parser state steps between the input register
// and the result register, and a result is loaded when it steps on the
// checksum's last character. The user must write timezone_offset (reset 4)
// through cfg_wr_en / cfg_wr_data only while the block is idle; this
// is not enforced. A leading hour zero is shown as 10 (blank) in hour_tens.
module nmea_rmc_time_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: timezone_offset
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [3:0] hour_tens, [7:4] hour_ones,
                                   // [11:8] minute_tens, [15:12] minute_ones
);
    import nmea_rmc_pkg::*;

    // Parser states
    localparam logic [3:0] ST_HUNT  = 4'd0;
    localparam logic [3:0] ST_HDR_G = 4'd1;
    localparam logic [3:0] ST_HDR_P = 4'd2;
    localparam logic [3:0] ST_HDR_R = 4'd3;
    localparam logic [3:0] ST_HDR_M = 4'd4;
    localparam logic [3:0] ST_HDR_C = 4'd5;
    localparam logic [3:0] ST_COMMA = 4'd6;
    localparam logic [3:0] ST_TIME  = 4'd7;
    localparam logic [3:0] ST_BODY  = 4'd8;
    localparam logic [3:0] ST_CK_HI = 4'd9;
    localparam logic [3:0] ST_CK_LO = 4'd10;

    // Characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] HEX_ALPHA = 8'h37;
    localparam logic [FIELD_CNT_W-1:0] HOUR_MIN_CHARS = FIELD_CNT_W'(7);
    localparam logic [FIELD_CNT_W-1:0] KEPT_DIGITS    = FIELD_CNT_W'(4);
    localparam logic [FIELD_CNT_W-1:0] CNT_MAX        = FIELD_CNT_W'(TIME_FIELD_MAX);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       advance;

    // Parser state
    logic [3:0]             state_reg, state_next;
    logic [FIELD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]             rxor_reg, rxor_next;
    logic [7:0]             sxor_reg, sxor_next;
    digit_t                 ckhi_reg, ckhi_next;
    digit_t                 dig_reg  [4];
    digit_t                 dig_next [4];
    logic [TZ_W-1:0]        tz_reg;

    // Result register
    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic        emit;
    logic [15:0] emit_data;

    hour_pair_t hour_cur;
    hour_pair_t hour_adj;
    logic [7:0] hex_byte;
    digit_t     hex_nib;
    logic [7:0] b;

    // Parser steps when a byte is held and the result slot can take a beat
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign hour_cur.tens = dig_reg[0];
    assign hour_cur.ones = dig_reg[1];

    nmea_rmc_hour_adj u_hour_adj (
        .hour_in  (hour_cur),
        .tz       (tz_reg),
        .hour_out (hour_adj)
    );

    // Checksum hex digit decode
    always_comb begin
        b        = in_byte_reg;
        hex_byte = (b > CH_NINE) ? (b - HEX_ALPHA) : b;
        hex_nib  = hex_byte[DIGIT_W-1:0];
    end

    // Parser next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sxor_next  = sxor_reg;
        ckhi_next  = ckhi_reg;
        for (int i = 0; i < 4; i++) begin
            dig_next[i] = dig_reg[i];
        end
        emit      = 1'b0;
        emit_data = {dig_reg[3], dig_reg[2], dig_reg[1],
                     (dig_reg[0] == digit_t'(0)) ? digit_t'(10) : dig_reg[0]};
        rxor_next = (b != CH_STAR) ? (rxor_reg ^ b) : rxor_reg;

        case (state_reg)
            ST_HUNT: begin
                state_next = (b == CH_DOLLAR) ? ST_HDR_G : ST_HUNT;
                rxor_next  = 8'd0;
            end
            ST_HDR_G: state_next = (b == CH_G) ? ST_HDR_P : ST_HUNT;
            ST_HDR_P: state_next = (b == CH_P) ? ST_HDR_R : ST_HUNT;
            ST_HDR_R: state_next = (b == CH_R) ? ST_HDR_M : ST_HUNT;
            ST_HDR_M: state_next = (b == CH_M) ? ST_HDR_C : ST_HUNT;
            ST_HDR_C: state_next = (b == CH_C) ? ST_COMMA : ST_HUNT;
            ST_COMMA: begin
                cnt_next   = '0;
                state_next = (b == CH_COMMA) ? ST_TIME : ST_HUNT;
            end
            ST_TIME: begin
                if (b == CH_COMMA) begin
                    // Rewrite the hour only for a full hhmmss.ss style field
                    if (cnt_reg > HOUR_MIN_CHARS) begin
                        dig_next[0] = hour_adj.tens;
                        dig_next[1] = hour_adj.ones;
                    end
                    cnt_next   = '0;
                    state_next = ST_BODY;
                end else if (cnt_reg < CNT_MAX) begin
                    if (cnt_reg < KEPT_DIGITS) begin
                        dig_next[cnt_reg[1:0]] = b[DIGIT_W-1:0];
                    end
                    cnt_next = cnt_reg + FIELD_CNT_W'(1);
                end
            end
            ST_BODY: begin
                if (b == CH_STAR) begin
                    sxor_next  = rxor_reg;
                    state_next = ST_CK_HI;
                end
            end
            ST_CK_HI: begin
                ckhi_next  = hex_nib;
                state_next = ST_CK_LO;
            end
            ST_CK_LO: begin
                emit = ({ckhi_reg, hex_nib} == sxor_reg);
                for (int i = 0; i < 4; i++) begin
                    dig_next[i] = digit_t'(0);
                end
                state_next = ST_HUNT;
            end
            default: state_next = ST_HUNT;
        endcase
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Parser state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            cnt_reg   <= '0;
            rxor_reg  <= 8'd0;
            sxor_reg  <= 8'd0;
            ckhi_reg  <= '0;
            tz_reg    <= TZ_RESET;
            for (int i = 0; i < 4; i++) begin
                dig_reg[i] <= '0;
            end
        end else begin
            if (advance) begin
                state_reg <= state_next;
                cnt_reg   <= cnt_next;
                rxor_reg  <= rxor_next;
                sxor_reg  <= sxor_next;
                ckhi_reg  <= ckhi_next;
                for (int i = 0; i < 4; i++) begin
                    dig_reg[i] <= dig_next[i];
                end
            end
            if (cfg_wr_en) begin
                tz_reg <= cfg_wr_data;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= emit;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            m_data_reg <= emit_data;
        end
    end

endmodule

[hw/rtl/nmea_rmc_hour_adj.sv]
// Hour rewrite: 12-hour wrap, timezone subtraction with wrap, back to two digits.
module nmea_rmc_hour_adj (
    input  nmea_rmc_pkg::hour_pair_t       hour_in,
    input  logic [nmea_rmc_pkg::TZ_W-1:0]  tz,
    output nmea_rmc_pkg::hour_pair_t       hour_out
);
    import nmea_rmc_pkg::*;

    // Largest value is 15*10+15, fits in 8 bits
    logic [7:0] h_raw;
    logic [7:0] h_wrap;
    logic [7:0] h_up;
    logic [7:0] h_sub;
    logic [7:0] h_low;
    logic [7:0] tz_ext;

    always_comb begin
        tz_ext = {{(8-TZ_W){1'b0}}, tz};
        h_raw  = 8'({4'd0, hour_in.tens} * 8'd10) + {4'd0, hour_in.ones};
        // Wrap 13..: subtract once
        h_wrap = (h_raw > 8'd12) ? (h_raw - 8'd12) : h_raw;
        // Borrow a half day when the offset would go below one
        h_up   = (h_wrap <= tz_ext) ? (h_wrap + 8'd12) : h_wrap;
        h_sub  = h_up - tz_ext;
        if (h_sub > 8'd9) begin
            hour_out.tens = digit_t'(1);
            h_low         = h_sub - 8'd10;
        end else begin
            hour_out.tens = digit_t'(0);
            h_low         = h_sub;
        end
        hour_out.ones = h_low[DIGIT_W-1:0];
    end

endmodule
